### hw/rtl/clt_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and helper functions of the command latency tracker.
// Depends on nothing; every other file of the block but clt_ram uses it by scoped names.
package clt_pkg;

    localparam int PEND_DEPTH = 64;
    localparam int WIN_DEPTH  = 64;
    localparam int TIME_W     = 32;

    localparam int ACT_W      = 2;
    localparam int SEQ_W      = 16;
    localparam int AGE_W      = 32;
    localparam int LEN_W      = 7;
    localparam int OUT_W      = 32;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    localparam int PEND_AW = (PEND_DEPTH > 1) ? $clog2(PEND_DEPTH) : 1;
    localparam int PEND_CW = $clog2(PEND_DEPTH + 1);
    localparam int WIN_AW  = (WIN_DEPTH > 1) ? $clog2(WIN_DEPTH) : 1;
    localparam int WIN_CW  = $clog2(WIN_DEPTH + 1);
    localparam int WIN_IW  = WIN_CW + 1;
    localparam int SUM_W   = TIME_W + WIN_CW;
    localparam int DIV_CW  = $clog2(SUM_W + 1);
    localparam int PEND_W  = SEQ_W + TIME_W;

    localparam logic [ACT_W-1:0] ACT_SEND  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_ECHO  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_AGE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIN_LEN = 1'd1;

    localparam logic [AGE_W-1:0] MAX_AGE_RESET = 32'd100000;
    localparam logic [LEN_W-1:0] WIN_LEN_RESET = 7'd64;

    typedef struct packed {
        logic load;
        logic scan_run;
        logic scan_commit;
        logic shift_init;
        logic append;
        logic ev_rd;
        logic ev_sub;
        logic push_wr;
        logic clear;
        logic st_init;
        logic div_run;
        logic cand_rd;
        logic cand_ld;
        logic sweep_run;
        logic rank_next;
        logic out_load;
    } t_ctl_cmd;

    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic             scan_done;
        logic             scan_full;
        logic             found;
        logic             ev_need;
        logic             win_empty;
        logic             div_done;
        logic             sweep_done;
        logic             rank_hit;
        logic             out_free;
    } t_ctl_sts;

    // Position of the 95th percentile, floor(95*n/100), by a reciprocal multiply.
    function automatic logic [WIN_CW-1:0] rank_of(input logic [WIN_CW-1:0] cnt);
        logic [31:0]       prod;
        logic [47:0]       scaled;
        logic [WIN_CW-1:0] r;
        prod   = 32'(cnt) * 32'd95;
        scaled = 48'(prod) * 48'd5243;
        r      = WIN_CW'(scaled >> 19);
        if (r >= cnt && cnt != '0) begin
            r = cnt - WIN_CW'(1);
        end
        return r;
    endfunction

    // Circular index of the k-th sample after the head.
    function automatic logic [WIN_AW-1:0] win_index(input logic [WIN_AW-1:0] head,
                                                    input logic [WIN_CW-1:0] k);
        logic [WIN_IW-1:0] s;
        s = WIN_IW'(head) + WIN_IW'(k);
        if (s >= WIN_IW'(WIN_DEPTH)) begin
            s = s - WIN_IW'(WIN_DEPTH);
        end
        return s[WIN_AW-1:0];
    endfunction

endpackage

### hw/rtl/clt_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the event items and the result items.
// Depends on clt_pkg for field widths.
interface clt_in_if;
    logic                        valid;
    logic                        ready;
    logic [clt_pkg::ACT_W-1:0]   action;
    logic [clt_pkg::SEQ_W-1:0]   seq_number;
    logic [clt_pkg::TIME_W-1:0]  timestamp;

    modport source(output valid, action, seq_number, timestamp, input ready);
    modport sink(input valid, action, seq_number, timestamp, output ready);
endinterface

interface clt_out_if;
    logic                        valid;
    logic                        ready;
    logic                        matched;
    logic [clt_pkg::OUT_W-1:0]   latency;
    logic                        pending_overflow;
    logic [clt_pkg::LEN_W-1:0]   sample_count;
    logic [clt_pkg::OUT_W-1:0]   mean_latency;
    logic [clt_pkg::OUT_W-1:0]   max_latency;
    logic [clt_pkg::OUT_W-1:0]   p95_latency;

    modport source(output valid, matched, latency, pending_overflow, sample_count,
                   mean_latency, max_latency, p95_latency, input ready);
    modport sink(input valid, matched, latency, pending_overflow, sample_count,
                 mean_latency, max_latency, p95_latency, output ready);
endinterface

### hw/rtl/command_latency_tracker.sv
`timescale 1ns / 1ps
// Top level of the command latency tracker: controller plus datapath.
// Depends on clt_pkg, clt_if, clt_ctrl and clt_datapath.
//
//  channel | dir | handshake       | payload
//  --------+-----+-----------------+-----------------------------------------
//  i_in    | in  | valid/ready     | action, seq_number, timestamp
//  o_out   | out | valid/ready     | matched, latency, pending_overflow,
//          |     |                 | sample_count, mean/max/p95 latency
//  cfg     | in  | i_cfg_we        | i_cfg_index, i_cfg_data
//
// One item at a time: accept and decode, sweep the pending table (a second sweep
// moves the entries down when a full table drops its oldest), append a send or
// store a sample after evicting the oldest as needed, set up, run the mean
// divider and the percentile search over the samples, which dominates, then finish.
// A waiting result sits in the output register while the next item is worked;
// the block then stalls in its final step until that register frees up.
// Reset is synchronous, clears the counts and restores the default configuration.
module command_latency_tracker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    clt_in_if.sink                            i_in,
    clt_out_if.source                         o_out,
    input  logic                              i_cfg_we,
    input  logic [clt_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [clt_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    clt_pkg::t_ctl_cmd w_cmd;
    clt_pkg::t_ctl_sts w_sts;
    logic              w_in_ready;

    assign i_in.ready = w_in_ready;

    clt_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in.valid),
        .o_in_ready(w_in_ready),
        .i_sts     (w_sts),
        .o_cmd     (w_cmd)
    );

    clt_datapath u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_sts             (w_sts),
        .i_action          (i_in.action),
        .i_seq_number      (i_in.seq_number),
        .i_timestamp       (i_in.timestamp),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_out_ready       (o_out.ready),
        .o_out_valid       (o_out.valid),
        .o_matched         (o_out.matched),
        .o_latency         (o_out.latency),
        .o_pending_overflow(o_out.pending_overflow),
        .o_sample_count    (o_out.sample_count),
        .o_mean_latency    (o_out.mean_latency),
        .o_max_latency     (o_out.max_latency),
        .o_p95_latency     (o_out.p95_latency)
    );
endmodule

### hw/rtl/clt_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
module clt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

### hw/rtl/clt_ctrl.sv
`timescale 1ns / 1ps
// Sequencer of the latency tracker: walks one item through table sweep, window
// update, division and percentile ranking. Depends on clt_pkg.
module clt_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  clt_pkg::t_ctl_sts i_sts,
    output clt_pkg::t_ctl_cmd o_cmd
);
    typedef enum logic [4:0] {
        S_IDLE, S_DECODE, S_SCAN, S_SHIFT, S_APPEND, S_PUSH_CHK, S_EV_RD, S_EV_SUB,
        S_PUSH_WR, S_CLEAR, S_ST_INIT, S_DIV, S_RK_CAND, S_RK_CWAIT,
        S_RK_SWEEP, S_RK_CHECK, S_FINISH
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = S_DECODE;
                end
            end
            // The action is taken from the registered copy of the accepted item.
            S_DECODE: begin
                if (i_sts.action == clt_pkg::ACT_SEND ||
                    i_sts.action == clt_pkg::ACT_ECHO) begin
                    n_state = S_SCAN;
                end else if (i_sts.action == clt_pkg::ACT_CLEAR) begin
                    n_state = S_CLEAR;
                end else begin
                    n_state = S_ST_INIT;
                end
            end
            S_SCAN: begin
                o_cmd.scan_run = 1'b1;
                if (i_sts.scan_done) begin
                    o_cmd.scan_commit = 1'b1;
                    if (i_sts.action == clt_pkg::ACT_SEND) begin
                        if (i_sts.scan_full) begin
                            o_cmd.shift_init = 1'b1;
                            n_state = S_SHIFT;
                        end else begin
                            n_state = S_APPEND;
                        end
                    end else if (i_sts.found) begin
                        n_state = S_PUSH_CHK;
                    end else begin
                        n_state = S_ST_INIT;
                    end
                end
            end
            S_SHIFT: begin
                o_cmd.scan_run = 1'b1;
                if (i_sts.scan_done) begin
                    o_cmd.scan_commit = 1'b1;
                    n_state = S_APPEND;
                end
            end
            S_APPEND: begin
                o_cmd.append = 1'b1;
                n_state = S_ST_INIT;
            end
            S_PUSH_CHK: begin
                n_state = i_sts.ev_need ? S_EV_RD : S_PUSH_WR;
            end
            S_EV_RD: begin
                o_cmd.ev_rd = 1'b1;
                n_state = S_EV_SUB;
            end
            S_EV_SUB: begin
                o_cmd.ev_sub = 1'b1;
                n_state = S_PUSH_CHK;
            end
            S_PUSH_WR: begin
                o_cmd.push_wr = 1'b1;
                n_state = S_ST_INIT;
            end
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                n_state = S_ST_INIT;
            end
            S_ST_INIT: begin
                o_cmd.st_init = 1'b1;
                n_state = i_sts.win_empty ? S_FINISH : S_DIV;
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    n_state = S_RK_CAND;
                end else begin
                    o_cmd.div_run = 1'b1;
                end
            end
            S_RK_CAND: begin
                o_cmd.cand_rd = 1'b1;
                n_state = S_RK_CWAIT;
            end
            S_RK_CWAIT: begin
                o_cmd.cand_ld = 1'b1;
                n_state = S_RK_SWEEP;
            end
            S_RK_SWEEP: begin
                o_cmd.sweep_run = 1'b1;
                if (i_sts.sweep_done) begin
                    n_state = S_RK_CHECK;
                end
            end
            S_RK_CHECK: begin
                o_cmd.rank_next = 1'b1;
                n_state = i_sts.rank_hit ? S_FINISH : S_RK_CAND;
            end
            S_FINISH: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end
endmodule

### hw/rtl/clt_datapath.sv
`timescale 1ns / 1ps
// Datapath of the latency tracker: pending table, sample window, divider,
// rank counter, configuration and result registers. Depends on clt_pkg, clt_ram.
module clt_datapath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  clt_pkg::t_ctl_cmd                 i_cmd,
    output clt_pkg::t_ctl_sts                 o_sts,
    input  logic [clt_pkg::ACT_W-1:0]         i_action,
    input  logic [clt_pkg::SEQ_W-1:0]         i_seq_number,
    input  logic [clt_pkg::TIME_W-1:0]        i_timestamp,
    input  logic                              i_cfg_we,
    input  logic [clt_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [clt_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                              i_out_ready,
    output logic                              o_out_valid,
    output logic                              o_matched,
    output logic [clt_pkg::OUT_W-1:0]         o_latency,
    output logic                              o_pending_overflow,
    output logic [clt_pkg::LEN_W-1:0]         o_sample_count,
    output logic [clt_pkg::OUT_W-1:0]         o_mean_latency,
    output logic [clt_pkg::OUT_W-1:0]         o_max_latency,
    output logic [clt_pkg::OUT_W-1:0]         o_p95_latency
);
    localparam int TW = clt_pkg::TIME_W;
    localparam int PC = clt_pkg::PEND_CW;
    localparam int PA = clt_pkg::PEND_AW;
    localparam int WC = clt_pkg::WIN_CW;
    localparam int WA = clt_pkg::WIN_AW;
    localparam int SW = clt_pkg::SUM_W;

    logic [clt_pkg::AGE_W-1:0]  r_max_age;
    logic [clt_pkg::LEN_W-1:0]  r_win_len;
    logic [clt_pkg::ACT_W-1:0]  r_action;
    logic [clt_pkg::SEQ_W-1:0]  r_seq;
    logic [TW-1:0]              r_now;

    logic [PC-1:0] r_pcount;
    logic [PC-1:0] r_rd;
    logic [PC-1:0] r_wr;
    logic          r_rvld;
    logic          r_keep_all;
    logic          r_found;
    logic [TW-1:0] r_lat;
    logic          r_ovf;

    logic [WA-1:0] r_whead;
    logic [WC-1:0] r_wcount;
    logic [SW-1:0] r_wsum;

    logic [SW-1:0]              r_dq;
    logic [WC-1:0]              r_drem;
    logic [clt_pkg::DIV_CW-1:0] r_dcnt;

    logic [WC-1:0] r_i;
    logic [WC-1:0] r_j;
    logic [WC-1:0] r_jq;
    logic          r_svld;
    logic [TW-1:0] r_cand;
    logic [WC-1:0] r_below;
    logic [WC-1:0] r_rank;
    logic [TW-1:0] r_max;
    logic [TW-1:0] r_p95;

    logic                         p_we;
    logic [PA-1:0]                p_waddr;
    logic [clt_pkg::PEND_W-1:0]   p_wdata;
    logic [clt_pkg::PEND_W-1:0]   p_rdata;
    logic [clt_pkg::SEQ_W-1:0]    w_pnum;
    logic [TW-1:0]                w_ptime;
    logic [TW-1:0]                w_age;
    logic                         w_keep;
    logic                         w_hit;

    logic          w_we;
    logic [WA-1:0] w_waddr;
    logic [WA-1:0] w_raddr;
    logic [TW-1:0] w_rdata;
    logic [WC-1:0] w_len;

    logic [WC:0]   w_trial;
    logic          w_qbit;
    logic [WC-1:0] w_rem;

    // Pending table: sequence number above timestamp, oldest entry first.
    clt_ram #(.WIDTH(clt_pkg::PEND_W), .DEPTH(clt_pkg::PEND_DEPTH)) u_pend_ram (
        .i_clk  (i_clk),
        .i_we   (p_we),
        .i_waddr(p_waddr),
        .i_wdata(p_wdata),
        .i_raddr(r_rd[PA-1:0]),
        .o_rdata(p_rdata)
    );

    clt_ram #(.WIDTH(TW), .DEPTH(clt_pkg::WIN_DEPTH)) u_win_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(r_lat),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    always_comb begin
        w_pnum  = p_rdata[TW +: clt_pkg::SEQ_W];
        w_ptime = p_rdata[TW-1:0];
        w_age   = r_now - w_ptime;
        w_keep  = r_keep_all || (w_age <= r_max_age);
        // The first surviving entry with the echoed number is taken out.
        w_hit   = !r_keep_all && (r_action == clt_pkg::ACT_ECHO) && w_keep
                  && !r_found && (w_pnum == r_seq);

        p_we    = 1'b0;
        p_waddr = r_wr[PA-1:0];
        p_wdata = p_rdata;
        if (i_cmd.append) begin
            p_we    = 1'b1;
            p_waddr = r_pcount[PA-1:0];
            p_wdata = {r_seq, r_now};
        end else if (i_cmd.scan_run && r_rvld && w_keep && !w_hit) begin
            p_we = 1'b1;
        end

        if (r_win_len == '0) begin
            w_len = WC'(1);
        end else if (int'(r_win_len) > clt_pkg::WIN_DEPTH) begin
            w_len = WC'(clt_pkg::WIN_DEPTH);
        end else begin
            w_len = WC'(r_win_len);
        end

        w_we    = i_cmd.push_wr;
        w_waddr = clt_pkg::win_index(r_whead, r_wcount);
        if (i_cmd.ev_rd) begin
            w_raddr = r_whead;
        end else if (i_cmd.cand_rd) begin
            w_raddr = clt_pkg::win_index(r_whead, r_i);
        end else begin
            w_raddr = clt_pkg::win_index(r_whead, r_j);
        end

        w_trial = {r_drem, r_dq[SW-1]};
        w_qbit  = (w_trial >= {1'b0, r_wcount});
        w_rem   = w_qbit ? WC'(w_trial - {1'b0, r_wcount}) : WC'(w_trial);
    end

    always_comb begin
        o_sts            = '0;
        o_sts.action     = r_action;
        o_sts.scan_done  = (r_rd == r_pcount) && !r_rvld;
        o_sts.scan_full  = (r_wr == PC'(clt_pkg::PEND_DEPTH));
        o_sts.found      = r_found;
        o_sts.ev_need    = (r_wcount >= w_len);
        o_sts.win_empty  = (r_wcount == '0);
        o_sts.div_done   = (r_dcnt == clt_pkg::DIV_CW'(SW));
        o_sts.sweep_done = (r_j == r_wcount) && !r_svld;
        o_sts.rank_hit   = (r_below == r_rank);
        o_sts.out_free   = !o_out_valid || i_out_ready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_age   <= clt_pkg::MAX_AGE_RESET;
            r_win_len   <= clt_pkg::WIN_LEN_RESET;
            r_pcount    <= '0;
            r_rvld      <= 1'b0;
            r_whead     <= '0;
            r_wcount    <= '0;
            r_wsum      <= '0;
            r_svld      <= 1'b0;
            o_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == clt_pkg::CFG_MAX_AGE) begin
                    r_max_age <= i_cfg_data;
                end else if (i_cfg_index == clt_pkg::CFG_WIN_LEN) begin
                    r_win_len <= i_cfg_data[clt_pkg::LEN_W-1:0];
                end
            end

            if (i_cmd.load) begin
                r_action   <= i_action;
                r_seq      <= i_seq_number;
                r_now      <= i_timestamp;
                r_rd       <= '0;
                r_wr       <= '0;
                r_rvld     <= 1'b0;
                r_keep_all <= 1'b0;
                r_found    <= 1'b0;
                r_lat      <= '0;
                r_ovf      <= 1'b0;
            end

            // One table entry read per cycle; survivors are packed down in place.
            if (i_cmd.scan_run) begin
                if (r_rd < r_pcount) begin
                    r_rd   <= r_rd + PC'(1);
                    r_rvld <= 1'b1;
                end else begin
                    r_rvld <= 1'b0;
                end
                if (r_rvld) begin
                    if (w_hit) begin
                        r_found <= 1'b1;
                        r_lat   <= w_age;
                    end else if (w_keep) begin
                        r_wr <= r_wr + PC'(1);
                    end
                end
            end
            if (i_cmd.scan_commit) begin
                r_pcount <= r_wr;
            end
            // A full table loses its oldest entry: move every other one down.
            // The read pipeline is already empty when the sweep ends.
            if (i_cmd.shift_init) begin
                r_rd       <= PC'(1);
                r_wr       <= '0;
                r_keep_all <= 1'b1;
                r_ovf      <= 1'b1;
            end
            if (i_cmd.append) begin
                r_pcount <= r_pcount + PC'(1);
            end

            if (i_cmd.ev_sub) begin
                r_wsum   <= r_wsum - SW'(w_rdata);
                r_whead  <= clt_pkg::win_index(r_whead, WC'(1));
                r_wcount <= r_wcount - WC'(1);
            end
            if (i_cmd.push_wr) begin
                r_wsum   <= r_wsum + SW'(r_lat);
                r_wcount <= r_wcount + WC'(1);
            end
            if (i_cmd.clear) begin
                r_pcount <= '0;
                r_whead  <= '0;
                r_wcount <= '0;
                r_wsum   <= '0;
            end

            if (i_cmd.st_init) begin
                r_dq   <= r_wsum;
                r_drem <= '0;
                r_dcnt <= '0;
                r_max  <= '0;
                r_p95  <= '0;
                r_i    <= '0;
                r_rank <= clt_pkg::rank_of(r_wcount);
            end
            // Restoring division, one quotient bit per cycle.
            if (i_cmd.div_run) begin
                r_drem <= w_rem;
                r_dq   <= {r_dq[SW-2:0], w_qbit};
                r_dcnt <= r_dcnt + clt_pkg::DIV_CW'(1);
            end

            if (i_cmd.cand_ld) begin
                r_cand  <= w_rdata;
                r_j     <= '0;
                r_svld  <= 1'b0;
                r_below <= '0;
            end
            // Count the samples ranked below the candidate; ties go by age.
            if (i_cmd.sweep_run) begin
                if (r_j < r_wcount) begin
                    r_j    <= r_j + WC'(1);
                    r_jq   <= r_j;
                    r_svld <= 1'b1;
                end else begin
                    r_svld <= 1'b0;
                end
                if (r_svld) begin
                    if (w_rdata < r_cand || (w_rdata == r_cand && r_jq < r_i)) begin
                        r_below <= r_below + WC'(1);
                    end
                    if (w_rdata > r_max) begin
                        r_max <= w_rdata;
                    end
                end
            end
            if (i_cmd.rank_next) begin
                if (r_below == r_rank) begin
                    r_p95 <= r_cand;
                end else begin
                    r_i <= r_i + WC'(1);
                end
            end

            if (i_cmd.out_load) begin
                o_out_valid        <= 1'b1;
                o_matched          <= r_found;
                o_latency          <= clt_pkg::OUT_W'(r_lat);
                o_pending_overflow <= r_ovf;
                o_sample_count     <= clt_pkg::LEN_W'(r_wcount);
                o_mean_latency     <= r_dq[clt_pkg::OUT_W-1:0];
                o_max_latency      <= clt_pkg::OUT_W'(r_max);
                o_p95_latency      <= clt_pkg::OUT_W'(r_p95);
            end else if (o_out_valid && i_out_ready) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    a_pcount_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pcount <= PC'(clt_pkg::PEND_DEPTH))
        else $error("pending count beyond table depth");

    a_wcount_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wcount <= WC'(clt_pkg::WIN_DEPTH))
        else $error("window count beyond window depth");

    a_empty_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wcount == '0 |-> r_wsum == '0)
        else $error("empty window carries a nonzero sum");

    a_load_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |=> o_out_valid)
        else $error("result load did not raise valid");
endmodule
